// ===== hdl/mss_pkg.sv =====
// Package for the median-of-sample-set unit.
// Holds parameter defaults and the truncating average helper.
// No dependencies.
package mss_pkg;

	localparam int MAX_SAMPLES_DEF = 32;
	localparam int SAMPLE_BITS_DEF = 16;

	// Average of two signed values, rounded toward zero, at a fixed width of 32 bits.
	// The caller truncates the result to its own sample width.
	function automatic logic signed [31:0] avg_trunc(input logic signed [31:0] a,
		input logic signed [31:0] b);
		logic signed [32:0] sum;
		logic signed [32:0] adj;
		sum = {a[31], a} + {b[31], b};
		adj = sum + 33'(sum[32]);
		return adj[32:1];
	endfunction

endpackage

// ===== hdl/median_of_sample_set_unit.sv =====
// Median of a signed sample set: top level with the cell chain and median logic.
// Depends on mss_pkg and mss_cell.
//
// Usage:
//   Input channel (in_valid/in_ready, sample, last_sample) takes one sample per
//   transaction. Samples are placed into a sorted chain of MAX_SAMPLES cells in
//   the cycle they are accepted, so a set streams in at one sample per cycle.
//   Samples arriving while the chain is full are dropped and flagged.
//   On the transaction marked last_sample, the block first picks the two middle
//   cells out of the chain (ST_MED), then forms their average (truncated toward
//   zero) in ST_AVG. in_ready is low in both states. The result then sits in an
//   output register (out_valid/out_ready, median_value, sample_count,
//   overflowed).
//   When the receiver stalls, the next set can already stream into the chain;
//   its last sample is still accepted, but then in_ready stays low until the
//   held result is taken.
//   Reset (arst_n low) empties the set, clears the drop flag and the output
//   valid; cell contents are not cleared and need no clearing pass.
module median_of_sample_set_unit
	import mss_pkg::*;
#(
	parameter int MAX_SAMPLES = MAX_SAMPLES_DEF,
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
	localparam int CW    = $clog2(MAX_SAMPLES + 1),
	localparam int IDX_W = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [SAMPLE_BITS-1:0] sample,
	input  logic                          last_sample,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [SAMPLE_BITS-1:0] median_value,
	output logic [CW-1:0]                 sample_count,
	output logic                          overflowed
);

	localparam int SB = SAMPLE_BITS;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_MED  = 2'd1;
	localparam logic [1:0] ST_AVG  = 2'd2;

	logic [1:0]           state_q;
	logic [CW-1:0]        count_q;
	logic                 dropped_q;
	logic                 in_acc;
	logic                 full;
	logic                 ins_en;

	logic signed [SB-1:0] cell_val [MAX_SAMPLES];
	logic                 cell_gt  [MAX_SAMPLES];

	logic [CW-1:0]        lo_cnt;
	logic [CW-1:0]        hi_cnt;
	logic signed [SB-1:0] lo_sel;
	logic signed [SB-1:0] hi_sel;
	logic signed [SB-1:0] lo_q;
	logic signed [SB-1:0] hi_q;
	logic [CW-1:0]        n_q;
	logic                 drop_lat_q;
	logic signed [31:0]   avg_full;

	logic                 out_valid_q;
	logic signed [SB-1:0] median_q;
	logic [CW-1:0]        cnt_out_q;
	logic                 ovf_q;
	logic                 out_load;

	assign in_ready = (state_q == ST_IDLE);
	assign in_acc   = in_valid && in_ready;
	assign full     = (count_q == CW'(MAX_SAMPLES));
	assign ins_en   = in_acc && !full;

	// sorted insertion chain
	for (genvar i = 0; i < MAX_SAMPLES; i++) begin : g_cell
		logic signed [SB-1:0] lv;
		logic                 lg;
		if (i == 0) begin : g_head
			assign lv = sample;
			assign lg = 1'b0;
		end else begin : g_body
			assign lv = cell_val[i-1];
			assign lg = cell_gt[i-1];
		end
		mss_cell #(.SB(SB), .CW(CW), .IDX(i)) u_cell (
			.clk        (clk),
			.ins_en     (ins_en),
			.count      (count_q),
			.sample     (sample),
			.left_value (lv),
			.left_gt    (lg),
			.value      (cell_val[i]),
			.gt         (cell_gt[i])
		);
	end

	// middle positions: equal for odd count, adjacent for even count
	assign lo_cnt = (count_q - CW'(1)) >> 1;
	assign hi_cnt = count_q >> 1;

	always_comb begin
		lo_sel = '0;
		hi_sel = '0;
		for (int i = 0; i < MAX_SAMPLES; i++) begin
			if (IDX_W'(i) == lo_cnt[IDX_W-1:0]) lo_sel = cell_val[i];
			if (IDX_W'(i) == hi_cnt[IDX_W-1:0]) hi_sel = cell_val[i];
		end
	end

	assign avg_full = avg_trunc(32'(lo_q), 32'(hi_q));
	assign out_load = (state_q == ST_AVG) && (!out_valid_q || out_ready);

	// control: set count, drop flag, sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			count_q   <= '0;
			dropped_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						if (full) dropped_q <= 1'b1;
						else      count_q   <= count_q + CW'(1);
						if (last_sample) state_q <= ST_MED;
					end
				end
				ST_MED: begin
					count_q   <= '0;
					dropped_q <= 1'b0;
					state_q   <= ST_AVG;
				end
				ST_AVG: begin
					if (out_load) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// latch the middle pair and set totals
	always_ff @(posedge clk) begin
		if (state_q == ST_MED) begin
			lo_q       <= lo_sel;
			hi_q       <= hi_sel;
			n_q        <= count_q;
			drop_lat_q <= dropped_q;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			median_q  <= avg_full[SB-1:0];
			cnt_out_q <= n_q;
			ovf_q     <= drop_lat_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign median_value = median_q;
	assign sample_count = cnt_out_q;
	assign overflowed   = ovf_q;

	// checks
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_SAMPLES))
		else $error("set count beyond capacity");

	a_last_goes_med: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && last_sample |=> state_q == ST_MED)
		else $error("last sample did not start median");

	a_med_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_MED |-> count_q != '0)
		else $error("median of empty set");

	a_out_from_avg: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == ST_AVG)
		else $error("result appeared without averaging");

endmodule

// ===== hdl/mss_cell.sv =====
// One cell of the sorted insertion chain: holds a single sample.
// Depends on mss_pkg for the default sample width.
module mss_cell
	import mss_pkg::*;
#(
	parameter int SB  = SAMPLE_BITS_DEF,
	parameter int CW  = 6,
	parameter int IDX = 0
) (
	input  logic                 clk,
	input  logic                 ins_en,
	input  logic [CW-1:0]        count,
	input  logic signed [SB-1:0] sample,
	input  logic signed [SB-1:0] left_value,
	input  logic                 left_gt,
	output logic signed [SB-1:0] value,
	output logic                 gt
);

	logic signed [SB-1:0] value_q;
	logic                 occ;

	// an empty cell acts as +infinity so the chain stays monotone
	assign occ   = CW'(IDX) < count;
	assign gt    = !occ || (value_q > sample);
	assign value = value_q;

	// shift right when the new sample sorts before this cell
	always_ff @(posedge clk) begin
		if (ins_en && gt) begin
			value_q <= left_gt ? left_value : sample;
		end
	end

endmodule

// ===== tb/median_checker.sv =====
// Checker for the median-of-sample-set unit: follows both channels, predicts
// the median of each set from the accepted samples and compares the results.
// No dependencies; its parameters are set to match the unit's.
module median_checker #(
	parameter int MAX_SAMPLES = 32,
	parameter int SAMPLE_BITS = 16,
	parameter int CW          = 6
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic                          in_ready,
	input  logic signed [SAMPLE_BITS-1:0] sample,
	input  logic                          last_sample,
	input  logic                          out_valid,
	input  logic                          out_ready,
	input  logic signed [SAMPLE_BITS-1:0] median_value,
	input  logic [CW-1:0]                 sample_count,
	input  logic                          overflowed,
	output int                            mismatches,
	output int                            results_pending,
	output int                            sets_seen,
	output int                            sets_with_drops
);

	typedef struct {
		logic signed [SAMPLE_BITS-1:0] median;
		logic [CW-1:0]                 count;
		logic                          dropped;
	} median_result_t;

	// predicted results in arrival order, and the running set kept ascending
	median_result_t                median_q[$];
	logic signed [SAMPLE_BITS-1:0] sorted_set[$];
	bit                            set_dropped = 1'b0;

	int error_cnt    = 0;
	int pending_cnt  = 0;
	int set_cnt      = 0;
	int drop_set_cnt = 0;
	int result_cnt   = 0;

	assign mismatches      = error_cnt;
	assign results_pending = pending_cnt;
	assign sets_seen       = set_cnt;
	assign sets_with_drops = drop_set_cnt;

	// Count a failure; only the first ten are printed.
	task automatic note_error(input string msg);
		if (error_cnt < 10)
			$display("ERROR @%0t: %s", $time, msg);
		error_cnt++;
	endtask

	always @(posedge clk) begin : watch
		int             pos;
		int             n;
		longint         mid_sum;
		median_result_t exp_res;
		median_result_t got;
		if (arst_n) begin
			// result channel: each transaction retires the oldest prediction
			if (out_valid && out_ready) begin
				got.median  = median_value;
				got.count   = sample_count;
				got.dropped = overflowed;
				result_cnt++;
				if (median_q.size() == 0) begin
					note_error($sformatf("result %0d arrived with none expected: median %0d count %0d dropped %0b",
						result_cnt, got.median, got.count, got.dropped));
				end else begin
					exp_res = median_q.pop_front();
					if (got.median !== exp_res.median || got.count !== exp_res.count ||
						got.dropped !== exp_res.dropped) begin
						note_error($sformatf({"result %0d: expected median %0d count %0d dropped %0b, ",
							"got median %0d count %0d dropped %0b"}, result_cnt,
							exp_res.median, exp_res.count, exp_res.dropped,
							got.median, got.count, got.dropped));
					end
				end
			end

			// sample channel: sorted insert, or drop once the store is full
			if (in_valid && in_ready) begin
				if (sorted_set.size() < MAX_SAMPLES) begin
					pos = sorted_set.size();
					while (pos > 0 && sorted_set[pos-1] > sample)
						pos--;
					sorted_set.insert(pos, sample);
				end else begin
					set_dropped = 1'b1;
				end
				if (last_sample) begin
					// middle value, or the two middle values averaged toward zero
					n = sorted_set.size();
					if (n[0]) begin
						exp_res.median = sorted_set[n/2];
					end else begin
						mid_sum = longint'(sorted_set[n/2-1]) + longint'(sorted_set[n/2]);
						exp_res.median = SAMPLE_BITS'(mid_sum / 2);
					end
					exp_res.count   = CW'(n);
					exp_res.dropped = set_dropped;
					median_q.push_back(exp_res);
					set_cnt++;
					if (set_dropped)
						drop_set_cnt++;
					sorted_set.delete();
					set_dropped = 1'b0;
				end
			end
			pending_cnt = median_q.size();
		end
	end

endmodule

// ===== tb/tb_median_of_sample_set_unit.sv =====
// Testbench top for the median-of-sample-set unit: drives sample sets through
// idle and stall phases and gives the verdict. Depends on mss_pkg, the unit
// and median_checker.
module tb_median_of_sample_set_unit;
	import mss_pkg::*;

	localparam int NSAMP       = MAX_SAMPLES_DEF;
	localparam int SBITS       = SAMPLE_BITS_DEF;
	localparam int CW          = $clog2(NSAMP + 1);
	localparam int QUIET_LIMIT = 4000;
	localparam int HOLD_CYCLES = 300;
	localparam int PHASE_ITEMS = 130;
	localparam logic signed [SBITS-1:0] S_MIN = {1'b1, {(SBITS-1){1'b0}}};
	localparam logic signed [SBITS-1:0] S_MAX = {1'b0, {(SBITS-1){1'b1}}};

	logic                    clk         = 1'b0;
	logic                    arst_n      = 1'b0;
	logic                    in_valid    = 1'b0;
	logic                    in_ready;
	logic signed [SBITS-1:0] sample      = '0;
	logic                    last_sample = 1'b0;
	logic                    out_valid;
	logic                    out_ready   = 1'b0;
	logic signed [SBITS-1:0] median_value;
	logic [CW-1:0]           sample_count;
	logic                    overflowed;

	// traffic shaping
	int send_idle    = 0;
	int stall_pct    = 0;
	int hold_len     = 0;
	bit hold_trigger = 1'b0;
	bit hold_seen    = 1'b0;
	int hold_left    = 0;

	int quiet_cycles = 0;
	int samples_sent = 0;
	int mismatches;
	int results_pending;
	int sets_seen;
	int sets_with_drops;

	median_of_sample_set_unit #(
		.MAX_SAMPLES(NSAMP),
		.SAMPLE_BITS(SBITS)
	) dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.sample      (sample),
		.last_sample (last_sample),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.median_value(median_value),
		.sample_count(sample_count),
		.overflowed  (overflowed)
	);

	median_checker #(
		.MAX_SAMPLES(NSAMP),
		.SAMPLE_BITS(SBITS),
		.CW         (CW)
	) median_chk (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.sample         (sample),
		.last_sample    (last_sample),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.median_value   (median_value),
		.sample_count   (sample_count),
		.overflowed     (overflowed),
		.mismatches     (mismatches),
		.results_pending(results_pending),
		.sets_seen      (sets_seen),
		.sets_with_drops(sets_with_drops)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Receiver: random stalls, plus a long hold-off on request
	always @(negedge clk) begin
		if (hold_trigger != hold_seen) begin
			hold_seen <= hold_trigger;
			hold_left <= hold_len;
			out_ready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	// Watchdog: too long without any transaction ends the run
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("Watchdog: no transaction for %0d cycles", quiet_cycles);
			$display("Mismatches found");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// One sample transaction; called and returns at a falling edge.
	task automatic send_sample(input logic signed [SBITS-1:0] value, input logic is_last);
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid    <= 1'b1;
		sample      <= value;
		last_sample <= is_last;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		samples_sent++;
		@(negedge clk);
	endtask

	// Whole sets with random lengths and contents until n_items samples are sent.
	task automatic send_random_sets(input int n_items, input bit short_sets);
		int                      done_items;
		int                      set_len;
		int                      pick;
		logic signed [SBITS-1:0] value;
		done_items = 0;
		while (done_items < n_items) begin
			pick = $urandom_range(99);
			if (short_sets)
				set_len = $urandom_range(2, 8);
			else if (pick < 65)
				set_len = $urandom_range(1, 8);
			else if (pick < 88)
				set_len = $urandom_range(9, NSAMP - 1);
			else
				set_len = $urandom_range(NSAMP, NSAMP + 8);
			for (int i = 0; i < set_len; i++) begin
				// extremes, near-zero values (many ties) and full-range values
				pick = $urandom_range(9);
				if (pick == 0)
					value = S_MIN;
				else if (pick == 1)
					value = S_MAX;
				else if (pick < 4)
					value = SBITS'(int'($urandom_range(16)) - 8);
				else
					value = SBITS'($urandom);
				send_sample(value, i == set_len - 1);
			end
			done_items += set_len;
		end
	endtask

	// Stop offering and let every predicted result come out.
	task automatic wait_results();
		in_valid <= 1'b0;
		while (results_pending != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	initial begin
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// single-sample sets at both extremes
		send_sample(S_MAX, 1'b1);
		send_sample(S_MIN, 1'b1);
		// even count at full scale: the sum must not wrap
		send_sample(S_MAX, 1'b0);
		send_sample(S_MAX, 1'b1);
		// negative odd sum rounds toward zero
		send_sample(SBITS'(-3), 1'b0);
		send_sample(SBITS'(0), 1'b1);
		// unsorted with equal values
		send_sample(SBITS'(5), 1'b0);
		send_sample(SBITS'(-7), 1'b0);
		send_sample(SBITS'(5), 1'b1);
		// store full: the last sample is dropped, the result still comes
		for (int i = 0; i <= NSAMP; i++)
			send_sample(i[0] ? S_MAX : S_MIN, i == NSAMP);
		wait_results();

		// free-running
		send_random_sets(PHASE_ITEMS, 1'b0);
		wait_results();

		// sender mostly idle
		send_idle = 87;
		send_random_sets(PHASE_ITEMS, 1'b0);
		wait_results();

		// receiver mostly stalled
		send_idle = 0;
		stall_pct <= 87;
		send_random_sets(PHASE_ITEMS, 1'b0);
		wait_results();

		// both sides idle now and then
		send_idle = 21;
		stall_pct <= 21;
		send_random_sets(PHASE_ITEMS, 1'b0);
		wait_results();

		// long receiver hold-off while the sender keeps pushing short sets
		send_idle = 0;
		stall_pct <= 0;
		hold_len <= HOLD_CYCLES;
		hold_trigger <= ~hold_trigger;
		send_random_sets(50, 1'b1);
		wait_results();

		$display("Covered %0d samples in %0d sets, %0d of them overfull with samples dropped.",
			samples_sent, sets_seen, sets_with_drops);
		$display({"Phases: free-running, sender gaps, receiver stalls, both, ",
			"and a %0d-cycle hold-off."}, HOLD_CYCLES);
		if (results_pending != 0)
			$display("ERROR: %0d expected results never arrived", results_pending);
		if (mismatches == 0 && results_pending == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
